FILE: rtl/core/ple_pkg.sv
package ple_pkg;

  localparam int OP_W   = 4;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 7;
  localparam int ST_W   = 2;
  localparam int FPOS_W = 6;
  localparam int CNT_W  = 7;

  localparam logic [OP_W-1:0] OP_INS_FIRST = 4'd0;
  localparam logic [OP_W-1:0] OP_INS_LAST  = 4'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 4'd2;
  localparam logic [OP_W-1:0] OP_DEL_FIRST = 4'd3;
  localparam logic [OP_W-1:0] OP_DEL_LAST  = 4'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 4'd5;
  localparam logic [OP_W-1:0] OP_READ      = 4'd6;
  localparam logic [OP_W-1:0] OP_FIND      = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd8;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [VAL_W-1:0]  found_value;
    logic [FPOS_W-1:0]        found_position;
    logic [CNT_W-1:0]         entry_count;
  } res_t;

endpackage

FILE: rtl/core/ple_if.sv
interface ple_in_if;
  import ple_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, op, value, position, input ready);
  modport sink   (input valid, op, value, position, output ready);
endinterface

interface ple_out_if;
  import ple_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] found_value;
  logic [FPOS_W-1:0]       found_position;
  logic [CNT_W-1:0]        entry_count;

  modport source (output valid, status, found_value, found_position, entry_count,
                  input ready);
  modport sink   (input valid, status, found_value, found_position, entry_count,
                  output ready);
endinterface

FILE: rtl/core/ple_ram.sv
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/ple_seq.sv
module ple_seq #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ple_in_if.sink                      in_req,
  output logic                        mem_we,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr,
  output logic [DATA_WIDTH-1:0]       mem_wdata,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr,
  input  logic [DATA_WIDTH-1:0]       mem_rdata,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ple_pkg::res_t               res
);
  import ple_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = CW + POS_W;
  localparam int SW = 4;

  localparam logic [SW-1:0] S_IDLE   = 4'd0;
  localparam logic [SW-1:0] S_UP     = 4'd1;
  localparam logic [SW-1:0] S_UPLAST = 4'd2;
  localparam logic [SW-1:0] S_PUT    = 4'd3;
  localparam logic [SW-1:0] S_DN     = 4'd4;
  localparam logic [SW-1:0] S_DNLAST = 4'd5;
  localparam logic [SW-1:0] S_RD     = 4'd6;
  localparam logic [SW-1:0] S_RDW    = 4'd7;
  localparam logic [SW-1:0] S_FIND   = 4'd8;
  localparam logic [SW-1:0] S_FLAST  = 4'd9;
  localparam logic [SW-1:0] S_DONE   = 4'd10;

  logic [SW-1:0]         state_r, state_nxt;
  logic [CW-1:0]         occ_r, occ_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         p_r, p_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic                  wpend_r, wpend_nxt;
  logic [AW-1:0]         wa_r, wa_nxt;
  logic                  chk_r, chk_nxt;
  logic [AW-1:0]         chk_idx_r;
  logic [ST_W-1:0]       st_r, st_nxt;
  logic [VAL_W-1:0]      fval_r, fval_nxt;
  logic [FPOS_W-1:0]     fpos_r, fpos_nxt;

  logic [63:0]   in_v64;
  logic [63:0]   rd_v64;
  logic [WW-1:0] occ_w;
  logic [WW-1:0] pos_w;
  logic [AW-1:0] last_idx;
  logic          full;
  logic          empty;
  logic          hit;

  assign in_v64   = 64'(in_req.value);
  assign rd_v64   = 64'(signed'(mem_rdata));
  assign occ_w    = WW'(occ_r);
  assign pos_w    = WW'(in_req.position);
  assign last_idx = AW'(occ_r - CW'(1));
  assign full     = (occ_r == CW'(CAPACITY));
  assign empty    = (occ_r == '0);
  assign hit      = chk_r && (mem_rdata == val_r);

  assign in_req.ready = (state_r == S_IDLE);

  // Write port: the new value in S_PUT, otherwise the word read in the previous cycle.
  assign mem_we    = (state_r == S_PUT) || wpend_r;
  assign mem_waddr = (state_r == S_PUT) ? p_r : wa_r;
  assign mem_wdata = (state_r == S_PUT) ? val_r : mem_rdata;
  assign mem_raddr = idx_r;

  assign res_valid          = (state_r == S_DONE);
  assign res.status         = st_r;
  assign res.found_value    = fval_r;
  assign res.found_position = fpos_r;
  assign res.entry_count    = CNT_W'(occ_r);

  always_comb begin
    logic          ins_go;
    logic          del_go;
    logic [AW-1:0] go_p;

    ins_go    = 1'b0;
    del_go    = 1'b0;
    go_p      = '0;
    state_nxt = state_r;
    occ_nxt   = occ_r;
    idx_nxt   = idx_r;
    p_nxt     = p_r;
    val_nxt   = val_r;
    st_nxt    = st_r;
    fval_nxt  = fval_r;
    fpos_nxt  = fpos_r;
    wpend_nxt = (state_r == S_UP) || (state_r == S_DN);
    chk_nxt   = (state_r == S_FIND);
    wa_nxt    = (state_r == S_UP) ? idx_r + AW'(1) : idx_r - AW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          val_nxt   = in_v64[DATA_WIDTH-1:0];
          st_nxt    = ST_OK;
          fval_nxt  = '0;
          fpos_nxt  = '0;
          state_nxt = S_DONE;
          unique case (in_req.op)
            OP_INS_FIRST: begin
              if (full) st_nxt = ST_FULL;
              else begin
                ins_go = 1'b1;
                go_p   = '0;
              end
            end
            OP_INS_LAST: begin
              if (full) st_nxt = ST_FULL;
              else begin
                ins_go = 1'b1;
                go_p   = AW'(occ_r);
              end
            end
            OP_INS_AT: begin
              if (full) st_nxt = ST_FULL;
              else if (pos_w > occ_w) st_nxt = ST_RANGE;
              else begin
                ins_go = 1'b1;
                go_p   = AW'(in_req.position);
              end
            end
            OP_DEL_FIRST: begin
              if (empty) st_nxt = ST_RANGE;
              else begin
                del_go = 1'b1;
                go_p   = '0;
              end
            end
            OP_DEL_LAST: begin
              if (empty) st_nxt = ST_RANGE;
              else occ_nxt = occ_r - CW'(1);
            end
            OP_DEL_AT: begin
              if (pos_w >= occ_w) st_nxt = ST_RANGE;
              else begin
                del_go = 1'b1;
                go_p   = AW'(in_req.position);
              end
            end
            OP_READ: begin
              if (pos_w >= occ_w) st_nxt = ST_RANGE;
              else begin
                idx_nxt   = AW'(in_req.position);
                state_nxt = S_RD;
              end
            end
            OP_FIND: begin
              if (empty) st_nxt = ST_NOTFOUND;
              else begin
                idx_nxt   = '0;
                state_nxt = S_FIND;
              end
            end
            OP_CLEAR: occ_nxt = '0;
            default:  st_nxt = ST_RANGE;
          endcase

          p_nxt = go_p;
          if (ins_go) begin
            // Append directly when nothing sits at or after the slot.
            if (CW'(go_p) == occ_r) state_nxt = S_PUT;
            else begin
              idx_nxt   = last_idx;
              state_nxt = S_UP;
            end
          end
          if (del_go) begin
            if (go_p == last_idx) occ_nxt = occ_r - CW'(1);
            else begin
              idx_nxt   = go_p + AW'(1);
              state_nxt = S_DN;
            end
          end
        end
      end
      S_UP: begin
        if (idx_r == p_r) state_nxt = S_UPLAST;
        else idx_nxt = idx_r - AW'(1);
      end
      S_UPLAST: state_nxt = S_PUT;
      S_PUT: begin
        occ_nxt   = occ_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_DN: begin
        if (idx_r == last_idx) state_nxt = S_DNLAST;
        else idx_nxt = idx_r + AW'(1);
      end
      S_DNLAST: begin
        occ_nxt   = occ_r - CW'(1);
        state_nxt = S_DONE;
      end
      S_RD: state_nxt = S_RDW;
      S_RDW: begin
        fval_nxt  = rd_v64[VAL_W-1:0];
        state_nxt = S_DONE;
      end
      S_FIND: begin
        if (hit) begin
          fpos_nxt  = FPOS_W'(chk_idx_r);
          state_nxt = S_DONE;
        end else if (idx_r == last_idx) begin
          state_nxt = S_FLAST;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_FLAST: begin
        if (hit) fpos_nxt = FPOS_W'(chk_idx_r);
        else st_nxt = ST_NOTFOUND;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      wpend_r <= 1'b0;
      chk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      wpend_r <= wpend_nxt;
      chk_r   <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    p_r       <= p_nxt;
    val_r     <= val_nxt;
    wa_r      <= wa_nxt;
    chk_idx_r <= idx_r;
    st_r      <= st_nxt;
    fval_r    <= fval_nxt;
    fpos_r    <= fpos_nxt;
  end

endmodule

FILE: rtl/core/positional_list_engine_unit.sv
// Bounded positional list of signed values, held in one synchronous RAM.
// in_req carries a request (op, value, position); out_res returns exactly one
// result per request (status, found_value, found_position, entry_count).
// Both channels hand over on valid && ready.
// One request is worked at a time; in_req.ready is high while the sequencer
// is idle. Clear, delete last, delete at the tail and rejected requests
// touch no RAM word; read fetches one word; delete at p moves the later
// entries down; insert at p moves them up and then writes the value (an
// append writes it directly); find scans from position 0 to the first match.
// Inserts and deletes move the later entries one RAM word per cycle through
// the single read and single write port; find scans one word per cycle.
// Reset empties the list (entry count zero); RAM contents are not cleared.
// The output register holds a result while out_res.ready is low, and a new
// request is already accepted meanwhile; a finished result waits in the
// sequencer until the output register frees up.
module positional_list_engine_unit #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  ple_in_if.sink     in_req,
  ple_out_if.source  out_res
);
  import ple_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic res_valid;
  logic res_ready;
  res_t res;

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;

  ple_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ple_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Take a new result when the register is empty or drains this cycle.
  assign res_ready     = !out_valid_r || out_res.ready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.status         = out_res_r.status;
  assign out_res.found_value    = out_res_r.found_value;
  assign out_res.found_position = out_res_r.found_position;
  assign out_res.entry_count    = out_res_r.entry_count;

endmodule

FILE: test/positional_list_engine_unit_test.sv
module positional_list_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int LIST_CAP     = 64;
  localparam int OP_TOP_CODE  = (1 << OP_W) - 1;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PRINT_LIMIT  = 100;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct {
    res_t            res;
    int unsigned     tag;
    logic [OP_W-1:0] op;
  } list_result_t;

  logic clk;
  logic rst_n;

  ple_in_if  in_req_if ();
  ple_out_if out_res_if ();

  positional_list_engine_unit #(
    .CAPACITY   (LIST_CAP),
    .DATA_WIDTH (VAL_W)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req_if),
    .out_res (out_res_if)
  );

  // shadow copy of the list
  logic signed [VAL_W-1:0] list_entries [LIST_CAP];
  int unsigned             list_count;

  list_result_t expected_results [$];
  list_result_t checked_result;
  int unsigned  request_count;
  int unsigned  fail_count;
  int unsigned  quiet_cycles;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void insert_entry(input int unsigned at,
                                       input logic signed [VAL_W-1:0] value);
    for (int unsigned i = list_count; i > at; i--)
      list_entries[i] = list_entries[i-1];
    list_entries[at] = value;
    list_count++;
  endfunction

  function automatic void remove_entry(input int unsigned at);
    for (int unsigned i = at; i + 1 < list_count; i++)
      list_entries[i] = list_entries[i+1];
    list_count--;
  endfunction

  function automatic res_t apply_request(input logic [OP_W-1:0] op,
                                         input logic signed [VAL_W-1:0] value,
                                         input logic [POS_W-1:0] position);
    res_t r;
    bit   hit;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    case (op)
      OP_INS_FIRST, OP_INS_LAST, OP_INS_AT: begin
        // fullness wins over a bad position
        if (list_count >= LIST_CAP) r.status = ST_FULL;
        else if (op == OP_INS_FIRST) insert_entry(0, value);
        else if (op == OP_INS_LAST) insert_entry(list_count, value);
        else if (position > list_count) r.status = ST_RANGE;
        else insert_entry(32'(position), value);
      end
      OP_DEL_FIRST: begin
        if (list_count == 0) r.status = ST_RANGE;
        else remove_entry(0);
      end
      OP_DEL_LAST: begin
        if (list_count == 0) r.status = ST_RANGE;
        else list_count--;
      end
      OP_DEL_AT: begin
        if (position >= list_count) r.status = ST_RANGE;
        else remove_entry(32'(position));
      end
      OP_READ: begin
        if (position >= list_count) r.status = ST_RANGE;
        else r.found_value = list_entries[position];
      end
      OP_FIND: begin
        for (int unsigned i = 0; i < list_count && !hit; i++) begin
          if (list_entries[i] == value) begin
            hit = 1'b1;
            r.found_position = FPOS_W'(i);
          end
        end
        if (!hit) r.status = ST_NOTFOUND;
      end
      OP_CLEAR: list_count = 0;
      default: r.status = ST_RANGE;
    endcase
    r.entry_count = CNT_W'(list_count);
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) begin
      case ($urandom_range(3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    // small pool: forces duplicates for find
    if (roll < 50) return VAL_W'($urandom_range(15) - 8);
    return $urandom();
  endfunction

  function automatic logic [POS_W-1:0] pick_position(input int unsigned last);
    if ($urandom_range(99) < 85) return POS_W'($urandom_range(last));
    return POS_W'($urandom_range(LIST_CAP));
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic check_field(input string field, input logic signed [63:0] got,
                             input logic signed [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("request %0d op %0d: %s is %0d, expected %0d",
                                checked_result.tag, checked_result.op, field, got, want));
  endtask

  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [VAL_W-1:0] value,
                              input logic [POS_W-1:0] position);
    list_result_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      in_req_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_req_if.valid    <= 1'b1;
    in_req_if.op       <= op;
    in_req_if.value    <= value;
    in_req_if.position <= position;
    do @(posedge clk); while (!in_req_if.ready);
    item.tag = request_count;
    item.op  = op;
    item.res = apply_request(op, value, position);
    request_count++;
    expected_results.push_back(item);
  endtask

  task automatic wait_drained();
    in_req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // empty list: every delete, read and find misses
    send_request(OP_DEL_FIRST, '0, '0);
    send_request(OP_DEL_LAST, '0, '0);
    send_request(OP_DEL_AT, '0, '0);
    send_request(OP_READ, '0, '0);
    send_request(OP_FIND, '0, '0);
    send_request(OP_INS_AT, VAL_MAX, 7'd1);
    send_request(OP_INS_LAST, VAL_MAX, '0);
    send_request(OP_INS_FIRST, VAL_MIN, '0);
    send_request(OP_INS_AT, '1, 7'd1);
    send_request(OP_INS_AT, '0, 7'd3);
    send_request(OP_INS_AT, VAL_MIN, 7'd5);
    send_request(OP_READ, '0, 7'd0);
    send_request(OP_READ, '0, 7'd3);
    send_request(OP_READ, '0, 7'd4);
    send_request(OP_READ, '0, POS_W'(LIST_CAP));
    send_request(OP_INS_LAST, '1, '0);
    send_request(OP_FIND, '1, '0);
    send_request(OP_FIND, VAL_MAX, '0);
    send_request(OP_FIND, VAL_W'(12345), '0);
    send_request(OP_DEL_AT, '0, 7'd1);
    send_request(OP_DEL_AT, '0, POS_W'(LIST_CAP));
    send_request(OP_DEL_FIRST, '0, '0);
    send_request(OP_DEL_LAST, '0, '0);
    send_request(OP_W'(OP_CLEAR + 1), '1, '1);
    send_request(OP_W'(OP_TOP_CODE), '0, '0);
    send_request(OP_CLEAR, '0, '0);
    send_request(OP_READ, '0, '0);
  endtask

  task automatic test_fill_and_overflow();
    logic [OP_W-1:0] op;
    while (list_count < LIST_CAP) begin
      case ($urandom_range(2))
        0: op = OP_INS_FIRST;
        1: op = OP_INS_LAST;
        default: op = OP_INS_AT;
      endcase
      send_request(op, pick_value(), POS_W'($urandom_range(list_count)));
    end
    send_request(OP_INS_FIRST, '1, '0);
    send_request(OP_INS_LAST, '1, '0);
    send_request(OP_INS_AT, '1, POS_W'(LIST_CAP));
    send_request(OP_INS_AT, '1, '0);
    send_request(OP_READ, '0, POS_W'(LIST_CAP - 1));
    send_request(OP_READ, '0, POS_W'(LIST_CAP));
    send_request(OP_FIND, list_entries[LIST_CAP-1], '0);
    send_request(OP_DEL_AT, '0, POS_W'(LIST_CAP));
    while (list_count > 0) begin
      case ($urandom_range(2))
        0: op = OP_DEL_FIRST;
        1: op = OP_DEL_LAST;
        default: op = OP_DEL_AT;
      endcase
      send_request(op, pick_value(), POS_W'($urandom_range(list_count - 1)));
    end
    send_request(OP_DEL_LAST, '0, '0);
  endtask

  task automatic random_requests(input int unsigned count);
    int unsigned             target;
    int unsigned             roll;
    bit                      grow;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    target = 0;
    for (int unsigned k = 0; k < count; k++) begin
      // steer the fill level toward a target that moves now and then
      if (k % 40 == 0) begin
        case ($urandom_range(3))
          0: target = 0;
          1: target = LIST_CAP;
          default: target = $urandom_range(LIST_CAP);
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 2) op = OP_W'($urandom_range(OP_TOP_CODE, OP_CLEAR + 1));
      else if (roll < 3) op = OP_CLEAR;
      else if (roll < 18) op = OP_READ;
      else if (roll < 30) op = OP_FIND;
      else begin
        grow = (list_count < target) ? ($urandom_range(99) < 80) : ($urandom_range(99) < 20);
        case ($urandom_range(2))
          0: op = grow ? OP_INS_FIRST : OP_DEL_FIRST;
          1: op = grow ? OP_INS_LAST : OP_DEL_LAST;
          default: op = grow ? OP_INS_AT : OP_DEL_AT;
        endcase
      end
      if (op == OP_FIND && list_count != 0 && $urandom_range(99) < 60)
        value = list_entries[$urandom_range(list_count - 1)];
      else
        value = pick_value();
      if (op == OP_INS_AT) position = pick_position(list_count);
      else position = pick_position(list_count == 0 ? 0 : list_count - 1);
      send_request(op, value, position);
    end
  endtask

  task automatic test_hold_off();
    // hold the sender until the list engine has nothing in flight
    wait_drained();
    random_requests(60);
  endtask

  always @(posedge clk) begin
    out_res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_res_if.valid && out_res_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        checked_result = expected_results.pop_front();
        check_field("status", 64'(out_res_if.status), 64'(checked_result.res.status));
        check_field("found_value", 64'(out_res_if.found_value),
                    64'(checked_result.res.found_value));
        check_field("found_position", 64'(out_res_if.found_position),
                    64'(checked_result.res.found_position));
        check_field("entry_count", 64'(out_res_if.entry_count),
                    64'(checked_result.res.entry_count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_req_if.valid && in_req_if.ready) ||
        (out_res_if.valid && out_res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("[%0t] ERROR: no request or result moved for %0d cycles",
               $realtime, STALL_LIMIT);
      $display("** positional_list_engine_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_req_if.valid    = 1'b0;
    in_req_if.op       = OP_CLEAR;
    in_req_if.value    = '0;
    in_req_if.position = '0;
    list_count         = 0;
    request_count      = 0;
    fail_count         = 0;
    send_idle_pct      = 9;
    recv_idle_pct      = 66;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_overflow();
    random_requests(520);

    send_idle_pct = 66;
    recv_idle_pct = 9;
    random_requests(250);
    test_hold_off();
    random_requests(250);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(600);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** positional_list_engine_unit: PASSED **");
    end else begin
      $display("** positional_list_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
